// ===== hw/rtl/sst_pkg.sv =====
// sst_pkg: token kinds, scan modes, beat structs and keyword table for the tokenizer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package sst_pkg;

    localparam int POSITION_BITS_DEF = 16;
    localparam int MAX_KEYWORD_CHARS = 8;
    localparam int POS_W = 16;
    localparam int NUM_KEYWORDS = 33;
    localparam int MAX_RESULTS = 3;

    localparam logic [6:0] K_LPAREN = 7'd0;
    localparam logic [6:0] K_RPAREN = 7'd1;
    localparam logic [6:0] K_LBRACE = 7'd2;
    localparam logic [6:0] K_RBRACE = 7'd3;
    localparam logic [6:0] K_COMMA = 7'd4;
    localparam logic [6:0] K_COLON = 7'd5;
    localparam logic [6:0] K_SEMI = 7'd6;
    localparam logic [6:0] K_MINUS = 7'd7;
    localparam logic [6:0] K_PLUS = 7'd8;
    localparam logic [6:0] K_STAR = 7'd9;
    localparam logic [6:0] K_MOD = 7'd10;
    localparam logic [6:0] K_XOR = 7'd11;
    localparam logic [6:0] K_TILDE = 7'd12;
    localparam logic [6:0] K_SLASH = 7'd13;
    localparam logic [6:0] K_BANG = 7'd14;
    localparam logic [6:0] K_BANG_EQ = 7'd15;
    localparam logic [6:0] K_EQ = 7'd16;
    localparam logic [6:0] K_EQ_EQ = 7'd17;
    localparam logic [6:0] K_GT = 7'd18;
    localparam logic [6:0] K_GE = 7'd19;
    localparam logic [6:0] K_SHR = 7'd20;
    localparam logic [6:0] K_LT = 7'd21;
    localparam logic [6:0] K_LE = 7'd22;
    localparam logic [6:0] K_SHL = 7'd23;
    localparam logic [6:0] K_AND = 7'd24;
    localparam logic [6:0] K_AND_AND = 7'd25;
    localparam logic [6:0] K_OR = 7'd26;
    localparam logic [6:0] K_OR_OR = 7'd27;
    localparam logic [6:0] K_KEYWORD0 = 7'd28;
    localparam logic [6:0] K_IDENT = 7'd61;
    localparam logic [6:0] K_NUMBER = 7'd62;
    localparam logic [6:0] K_STRING = 7'd63;
    localparam logic [6:0] K_ERR_UNTERM = 7'd64;
    localparam logic [6:0] K_ERR_UNKNOWN = 7'd65;
    localparam logic [6:0] K_END = 7'd66;

    typedef enum logic [15:0] {
        M_IDLE  = 16'h0001,
        M_IDENT = 16'h0002,
        M_INT   = 16'h0004,
        M_DOT   = 16'h0008,
        M_X     = 16'h0010,
        M_FRAC  = 16'h0020,
        M_HEX   = 16'h0040,
        M_STR   = 16'h0080,
        M_CMT   = 16'h0100,
        M_SLASH = 16'h0200,
        M_BANG  = 16'h0400,
        M_EQ    = 16'h0800,
        M_GT    = 16'h1000,
        M_LT    = 16'h2000,
        M_AMP   = 16'h4000,
        M_PIPE  = 16'h8000
    } t_mode;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_text;
    } t_in_beat;

    typedef struct packed {
        logic [6:0]       token_kind;
        logic [POS_W-1:0] token_start;
        logic [POS_W-1:0] token_length;
        logic [POS_W-1:0] token_line;
        logic             last_of_run;
    } t_out_beat;

    // one result before line stamping
    typedef struct packed {
        logic       valid;
        logic [6:0] kind;
        logic [31:0] start;
        logic [31:0] len;
        logic [31:0] line;
    } t_tok;

    function automatic logic [63:0] kw_word(input int k);
        logic [63:0] w;
        w = 64'd0;
        case (k)
            0:  w = 64'h6669;
            1:  w = 64'h666965736c65;
            2:  w = 64'h65736c65;
            3:  w = 64'h74656c;
            4:  w = 64'h74736e6f63;
            5:  w = 64'h6e7275746572;
            6:  w = 64'h65757274;
            7:  w = 64'h65736c6166;
            8:  w = 64'h6c6c756e;
            9:  w = 64'h6e66;
            10: w = 64'h726f66;
            11: w = 64'h656c696877;
            12: w = 64'h746e697270;
            13: w = 64'h7265746e696f70;
            14: w = 64'h676e69727473;
            15: w = 64'h6c6f6f62;
            16: w = 64'h64696f76;
            17: w = 64'h38746e69;
            18: w = 64'h3631746e69;
            19: w = 64'h3233746e69;
            20: w = 64'h3436746e69;
            21: w = 64'h38746e6975;
            22: w = 64'h3631746e6975;
            23: w = 64'h3233746e6975;
            24: w = 64'h3436746e6975;
            25: w = 64'h3874616f6c66;
            26: w = 64'h36317461_6f6c66;
            27: w = 64'h32337461_6f6c66;
            28: w = 64'h34367461_6f6c66;
            29: w = 64'h3874616f6c6675;
            30: w = 64'h3631_74616f6c6675;
            31: w = 64'h3233_74616f6c6675;
            32: w = 64'h3436_74616f6c6675;
            default: w = 64'd0;
        endcase
        return w;
    endfunction

    function automatic logic [3:0] kw_len(input int k);
        logic [3:0] n;
        n = 4'd0;
        case (k)
            0, 9: n = 4'd2;
            3, 10: n = 4'd3;
            2, 6, 8, 15, 16, 17: n = 4'd4;
            4, 7, 11, 12, 18, 19, 20, 21: n = 4'd5;
            1, 5, 14, 22, 23, 24, 25: n = 4'd6;
            13, 26, 27, 28, 29: n = 4'd7;
            30, 31, 32: n = 4'd8;
            default: n = 4'd0;
        endcase
        return n;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/sst_kw_match.sv =====
// sst_kw_match: compares the buffered lexeme against the fixed keyword table
// depends on sst_pkg
`timescale 1ns / 1ps
`default_nettype none
module sst_kw_match (
    input  wire logic [63:0] i_word,
    input  wire logic [3:0]  i_len,
    input  wire logic        i_too_long,
    output logic [6:0]       o_kind
);
    import sst_pkg::*;

    always_comb begin
        o_kind = K_IDENT;
        if (!i_too_long) begin
            for (int k = NUM_KEYWORDS - 1; k >= 0; k--) begin
                if (kw_len(k) == i_len && kw_word(k) == i_word) begin
                    o_kind = K_KEYWORD0 + 7'(k);
                end
            end
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/sst_scan.sv =====
// sst_scan: scanner state and next-token logic for one source byte
// depends on sst_pkg, sst_kw_match
`timescale 1ns / 1ps
`default_nettype none
module sst_scan #(
    parameter int POSITION_BITS = sst_pkg::POSITION_BITS_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_step,
    input  wire sst_pkg::t_in_beat i_beat,
    output sst_pkg::t_tok        o_tok0,
    output sst_pkg::t_tok        o_tok1,
    output sst_pkg::t_tok        o_tok2
);
    import sst_pkg::*;

    localparam int PW = POSITION_BITS;
    localparam logic [PW:0] PMAX = {1'b0, {PW{1'b1}}};

    t_mode r_mode, n_mode;
    logic [PW-1:0] r_begin, n_begin, r_off, n_off, r_line, n_line, r_len, n_len;
    logic [7:0] r_pend, n_pend;
    logic [63:0] r_kw, n_kw;
    logic r_tl, n_tl;
    t_tok t0, t1, t2;
    logic [6:0] w_kind;
    logic [7:0] c;
    logic is_end, dig, alp, aln;

    function automatic logic [PW-1:0] sadd(input logic [PW-1:0] a, input logic [1:0] b);
        logic [PW:0] s;
        s = {1'b0, a} + {{(PW-1){1'b0}}, b};
        return (s > PMAX) ? PMAX[PW-1:0] : s[PW-1:0];
    endfunction

    function automatic logic [PW-1:0] sadd2(input logic [PW-1:0] a, input logic [PW-1:0] b);
        logic [PW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s > PMAX) ? PMAX[PW-1:0] : s[PW-1:0];
    endfunction

    sst_kw_match u_kw (
        .i_word    (r_kw),
        .i_len     ((r_len > PW'(MAX_KEYWORD_CHARS)) ? 4'hF : r_len[3:0]),
        .i_too_long(r_tl),
        .o_kind    (w_kind)
    );

    always_comb begin
        logic fed;
        logic [PW-1:0] lb;
        fed = 1'b0;
        lb = '0;
        c = i_beat.char_code;
        is_end = i_beat.end_of_text || (c == 8'd0);
        dig = (c >= "0") && (c <= "9");
        alp = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
        aln = dig || alp;
        n_mode = r_mode; n_begin = r_begin; n_off = r_off; n_line = r_line;
        n_len = r_len; n_pend = r_pend; n_kw = r_kw; n_tl = r_tl;
        t0 = '0; t1 = '0; t2 = '0;
        lb = r_line;

        // continue current token
        case (r_mode)
            M_IDENT: if (aln || c == "_") fed = 1'b1;
            M_INT: if (dig || c == "." || c == "x" || c == "X") fed = 1'b1;
            M_DOT: if (dig) fed = 1'b1;
            M_X: if (aln || c == "_") fed = 1'b1;
            M_FRAC, M_HEX: if (r_mode == M_FRAC ? dig : aln) fed = 1'b1;
            M_STR: fed = 1'b1;
            M_CMT: fed = (c != "\n");
            M_SLASH: fed = (c == "/");
            M_BANG, M_EQ: fed = (c == "=");
            M_GT: fed = (c == ">" || c == "=");
            M_LT: fed = (c == "<" || c == "=");
            M_AMP: fed = (c == "&");
            M_PIPE: fed = (c == "|");
            default: fed = 1'b0;
        endcase

        if (is_end || !fed) begin
            // flush pending token
            case (r_mode)
                M_IDENT: t0 = '{1'b1, w_kind, 32'(r_begin), 32'(r_len), 32'd0};
                M_INT, M_FRAC, M_HEX: t0 = '{1'b1, K_NUMBER, 32'(r_begin), 32'(r_len), 32'd0};
                M_DOT, M_X: begin
                    t0 = '{1'b1, K_NUMBER, 32'(r_begin), 32'(r_len), 32'd0};
                    t1 = '{1'b1, (r_mode == M_DOT) ? K_ERR_UNKNOWN : K_IDENT,
                           32'(sadd2(r_begin, r_len)), 32'd1, 32'd0};
                end
                M_STR: t0 = '{1'b1, K_ERR_UNTERM, 32'(r_begin), 32'(r_len), 32'd0};
                M_SLASH: t0 = '{1'b1, K_SLASH, 32'(r_begin), 32'd1, 32'd0};
                M_BANG: t0 = '{1'b1, K_BANG, 32'(r_begin), 32'd1, 32'd0};
                M_EQ: t0 = '{1'b1, K_EQ, 32'(r_begin), 32'd1, 32'd0};
                M_GT: t0 = '{1'b1, K_GT, 32'(r_begin), 32'd1, 32'd0};
                M_LT: t0 = '{1'b1, K_LT, 32'(r_begin), 32'd1, 32'd0};
                M_AMP: t0 = '{1'b1, K_AND, 32'(r_begin), 32'd1, 32'd0};
                M_PIPE: t0 = '{1'b1, K_OR, 32'(r_begin), 32'd1, 32'd0};
                default: ;
            endcase
            n_mode = M_IDLE;
        end

        if (is_end) begin
            t2 = '{1'b1, K_END, 32'(r_off), 32'd0, 32'd0};
            n_mode = M_IDLE; n_begin = '0; n_off = '0; n_line = PW'(1);
            n_pend = '0; n_kw = '0; n_tl = 1'b0; n_len = '0;
        end else if (fed) begin
            case (r_mode)
                M_IDENT: begin
                    if (r_len < PW'(MAX_KEYWORD_CHARS))
                        n_kw = r_kw | (64'(c) << {r_len[2:0], 3'b000});
                    else
                        n_tl = 1'b1;
                    n_len = sadd(r_len, 2'd1);
                end
                M_INT: begin
                    if (dig) n_len = sadd(r_len, 2'd1);
                    else begin
                        n_pend = c;
                        n_mode = (c == ".") ? M_DOT : M_X;
                    end
                end
                M_DOT: begin n_len = sadd(r_len, 2'd2); n_mode = M_FRAC; end
                M_X: begin
                    if (aln) begin n_len = sadd(r_len, 2'd2); n_mode = M_HEX; end
                    else begin
                        t0 = '{1'b1, K_NUMBER, 32'(r_begin), 32'(r_len), 32'd0};
                        n_begin = sadd2(r_begin, r_len);
                        n_kw = 64'(r_pend) | (64'(c) << 8);
                        n_tl = 1'b0;
                        n_len = PW'(2);
                        n_mode = M_IDENT;
                    end
                end
                M_FRAC, M_HEX: n_len = sadd(r_len, 2'd1);
                M_STR: begin
                    n_len = sadd(r_len, 2'd1);
                    if (c == "\"") begin
                        t0 = '{1'b1, K_STRING, 32'(r_begin), 32'(sadd(r_len, 2'd1)), 32'd0};
                        n_mode = M_IDLE;
                    end else if (c == "\n") n_line = sadd(r_line, 2'd1);
                end
                M_CMT: ;
                M_SLASH: n_mode = M_CMT;
                default: begin
                    // two-char operators
                    n_len = sadd(r_len, 2'd1);
                    n_mode = M_IDLE;
                    case (r_mode)
                        M_BANG: t0.kind = K_BANG_EQ;
                        M_EQ: t0.kind = K_EQ_EQ;
                        M_GT: t0.kind = (c == ">") ? K_SHR : K_GE;
                        M_LT: t0.kind = (c == "<") ? K_SHL : K_LE;
                        M_AMP: t0.kind = K_AND_AND;
                        default: t0.kind = K_OR_OR;
                    endcase
                    t0.valid = 1'b1;
                    t0.start = 32'(r_begin);
                    t0.len = 32'(sadd(r_len, 2'd1));
                end
            endcase
            n_off = sadd(r_off, 2'd1);
        end else begin
            // start a new token
            n_begin = r_off;
            n_len = PW'(1);
            n_mode = M_IDLE;
            if (dig) n_mode = M_INT;
            else if (alp) begin
                n_mode = M_IDENT; n_kw = 64'(c); n_tl = 1'b0;
            end else begin
                case (c)
                    "\"": n_mode = M_STR;
                    "(": t2 = '{1'b1, K_LPAREN, 32'(r_off), 32'd1, 32'd0};
                    ")": t2 = '{1'b1, K_RPAREN, 32'(r_off), 32'd1, 32'd0};
                    "{": t2 = '{1'b1, K_LBRACE, 32'(r_off), 32'd1, 32'd0};
                    "}": t2 = '{1'b1, K_RBRACE, 32'(r_off), 32'd1, 32'd0};
                    ",": t2 = '{1'b1, K_COMMA, 32'(r_off), 32'd1, 32'd0};
                    ":": t2 = '{1'b1, K_COLON, 32'(r_off), 32'd1, 32'd0};
                    ";": t2 = '{1'b1, K_SEMI, 32'(r_off), 32'd1, 32'd0};
                    "-": t2 = '{1'b1, K_MINUS, 32'(r_off), 32'd1, 32'd0};
                    "+": t2 = '{1'b1, K_PLUS, 32'(r_off), 32'd1, 32'd0};
                    "*": t2 = '{1'b1, K_STAR, 32'(r_off), 32'd1, 32'd0};
                    "%": t2 = '{1'b1, K_MOD, 32'(r_off), 32'd1, 32'd0};
                    "^": t2 = '{1'b1, K_XOR, 32'(r_off), 32'd1, 32'd0};
                    "~": t2 = '{1'b1, K_TILDE, 32'(r_off), 32'd1, 32'd0};
                    "/": n_mode = M_SLASH;
                    "!": n_mode = M_BANG;
                    "=": n_mode = M_EQ;
                    ">": n_mode = M_GT;
                    "<": n_mode = M_LT;
                    "&": n_mode = M_AMP;
                    "|": n_mode = M_PIPE;
                    " ", "\r", "\t": ;
                    "\n": n_line = sadd(r_line, 2'd1);
                    default: t2 = '{1'b1, K_ERR_UNKNOWN, 32'(r_off), 32'd1, 32'd0};
                endcase
            end
            n_off = sadd(r_off, 2'd1);
        end

        // line stamp: all tokens see line before update, except newline only
        // updates after any emits (new tokens carry old line)
        t0.line = 32'(lb);
        t1.line = 32'(lb);
        t2.line = 32'(lb);
    end

    assign o_tok0 = t0;
    assign o_tok1 = t1;
    assign o_tok2 = t2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE;
            r_begin <= '0;
            r_off <= '0;
            r_line <= PW'(1);
            r_len <= '0;
            r_pend <= '0;
            r_kw <= '0;
            r_tl <= 1'b0;
        end else if (i_step) begin
            r_mode <= n_mode;
            r_begin <= n_begin;
            r_off <= n_off;
            r_line <= n_line;
            r_len <= n_len;
            r_pend <= n_pend;
            r_kw <= n_kw;
            r_tl <= n_tl;
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/sst_out_queue.sv =====
// sst_out_queue: packs up to three tokens per byte, drains one beat a cycle
// while the receiver is ready; depends on sst_pkg
`timescale 1ns / 1ps
`default_nettype none
module sst_out_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_load,
    input  wire sst_pkg::t_tok i_tok0,
    input  wire sst_pkg::t_tok i_tok1,
    input  wire sst_pkg::t_tok i_tok2,
    output logic               o_empty_next,
    output logic               o_valid,
    input  wire logic          i_ready,
    output sst_pkg::t_out_beat o_beat
);
    import sst_pkg::*;

    t_tok r_q [MAX_RESULTS];
    logic [MAX_RESULTS-1:0] r_v;
    logic [MAX_RESULTS-1:0] r_last;
    logic [1:0] r_head;
    logic pop;
    t_tok w_head;

    assign o_valid = |r_v;
    assign pop = o_valid && i_ready;
    // accept when queue holds at most the beat now leaving
    assign o_empty_next = (r_v == '0) || (pop && $countones(r_v) == 1);

    always_comb begin
        w_head = r_q[r_head];
        o_beat.token_kind = w_head.kind;
        o_beat.token_start = w_head.start[POS_W-1:0];
        o_beat.token_length = w_head.len[POS_W-1:0];
        o_beat.token_line = w_head.line[POS_W-1:0];
        o_beat.last_of_run = r_last[r_head];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
            r_head <= '0;
        end else if (i_load) begin
            r_q[0] <= i_tok0;
            r_q[1] <= i_tok1;
            r_q[2] <= i_tok2;
            r_v <= {i_tok2.valid, i_tok1.valid, i_tok0.valid};
            r_last <= {i_tok2.valid, i_tok1.valid && !i_tok2.valid,
                       i_tok0.valid && !i_tok1.valid && !i_tok2.valid};
            r_head <= i_tok0.valid ? 2'd0 : (i_tok1.valid ? 2'd1 : 2'd2);
        end else if (pop) begin
            r_v[r_head] <= 1'b0;
            if (r_head != 2'd2 && r_v[r_head + 2'd1]) r_head <= r_head + 2'd1;
            else if (r_head == 2'd0 && r_v[2]) r_head <= 2'd2;
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/script_source_tokenizer.sv =====
// script_source_tokenizer: streaming source tokenizer top level
// depends on sst_pkg, sst_scan, sst_out_queue
//
// channel  direction  payload
// in       input      sst_pkg::t_in_beat  (char_code, end_of_text)
// out      output     sst_pkg::t_out_beat (kind, start, length, line, last)
//
// one byte a cycle while the output queue can accept it: the scan state updates
// and its tokens land in a three-entry output queue in the same edge
// a byte that yields more than one token holds input off while the queue
// drains; synchronous reset returns to offset 0, line 1
`timescale 1ns / 1ps
`default_nettype none
module script_source_tokenizer #(
    parameter int POSITION_BITS = sst_pkg::POSITION_BITS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire sst_pkg::t_in_beat i_data,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output sst_pkg::t_out_beat     o_data
);
    import sst_pkg::*;

    t_tok w_t0, w_t1, w_t2;
    logic w_step;

    assign w_step = i_valid && o_ready;

    sst_scan #(.POSITION_BITS(POSITION_BITS)) u_scan (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_step (w_step),
        .i_beat (i_data),
        .o_tok0 (w_t0),
        .o_tok1 (w_t1),
        .o_tok2 (w_t2)
    );

    sst_out_queue u_q (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_step),
        .i_tok0      (w_t0),
        .i_tok1      (w_t1),
        .i_tok2      (w_t2),
        .o_empty_next(o_ready),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_beat      (o_data)
    );
endmodule
`default_nettype wire

// ===== bench/tb_script_source_tokenizer.sv =====
// tb_script_source_tokenizer: self-checking bench for the streaming source tokenizer
// depends on sst_pkg and script_source_tokenizer; predicts tokens per input byte
`timescale 1ns / 1ps
`default_nettype none
module tb_script_source_tokenizer;
    import sst_pkg::*;

    typedef enum int {
        S_IDLE, S_IDENT, S_INT, S_DOT, S_X, S_FRAC, S_HEX, S_STR,
        S_CMT, S_SLASH, S_BANG, S_EQ, S_GT, S_LT, S_AMP, S_PIPE
    } t_scan;

    localparam int POS_MAX = 65535;
    localparam int WATCHDOG_LIMIT = 20000;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_ready;
    t_in_beat  i_data = '0;
    logic      o_valid;
    logic      i_ready = 1'b0;
    t_out_beat o_data;

    script_source_tokenizer DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_data(i_data), .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data)
    );

    always #1 i_clk = ~i_clk;

    // predictor state
    t_scan       lex_mode;
    int unsigned lex_begin, lex_offset, lex_line, lex_len;
    logic [7:0]  lex_pend;
    logic [63:0] lex_word;
    bit          lex_long;
    t_out_beat   tokens_due[$];
    t_out_beat   run_toks[$];

    int  fail_count = 0;
    int  idle_cycles = 0;
    bit  hold_off = 1'b0;
    int  hold_cycles = 0;
    bit  sender_busy = 1'b1;
    int  burst_left = 0;

    function automatic int unsigned sat(int unsigned a, int unsigned b);
        return (a + b > POS_MAX) ? POS_MAX : a + b;
    endfunction

    function automatic bit is_dig(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_alp(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    task automatic lex_clear();
        lex_mode = S_IDLE;
        lex_begin = 0;
        lex_offset = 0;
        lex_line = 1;
        lex_len = 0;
        lex_pend = 0;
        lex_word = 0;
        lex_long = 0;
    endtask

    function automatic void put_tok(logic [6:0] kind, int unsigned start, int unsigned len);
        t_out_beat t;
        if (run_toks.size() >= MAX_RESULTS) return;
        t.token_kind = kind;
        t.token_start = start[15:0];
        t.token_length = len[15:0];
        t.token_line = lex_line[15:0];
        t.last_of_run = 1'b0;
        run_toks.push_back(t);
    endfunction

    function automatic void ident_add(logic [7:0] c);
        if (lex_len < MAX_KEYWORD_CHARS) lex_word |= 64'(c) << (8 * lex_len);
        else lex_long = 1;
        lex_len = sat(lex_len, 1);
    endfunction

    // keyword table as lexeme strings, independent of the package words
    function automatic logic [6:0] word_kind();
        string names[33] = '{"if", "elseif", "else", "let", "const", "return", "true",
            "false", "null", "fn", "for", "while", "print", "pointer", "string", "bool",
            "void", "int8", "int16", "int32", "int64", "uint8", "uint16", "uint32",
            "uint64", "float8", "float16", "float32", "float64", "ufloat8", "ufloat16",
            "ufloat32", "ufloat64"};
        logic [63:0] w;
        if (lex_long || lex_len > MAX_KEYWORD_CHARS) return K_IDENT;
        for (int k = 0; k < 33; k++) begin
            w = 0;
            for (int n = 0; n < names[k].len(); n++) w |= 64'(names[k][n]) << (8 * n);
            if (names[k].len() == lex_len && w == lex_word) return K_KEYWORD0 + 7'(k);
        end
        return K_IDENT;
    endfunction

    task automatic lex_flush();
        case (lex_mode)
            S_IDENT: put_tok(word_kind(), lex_begin, lex_len);
            S_INT, S_FRAC, S_HEX: put_tok(K_NUMBER, lex_begin, lex_len);
            S_DOT: begin
                put_tok(K_NUMBER, lex_begin, lex_len);
                put_tok(K_ERR_UNKNOWN, sat(lex_begin, lex_len), 1);
            end
            S_X: begin
                put_tok(K_NUMBER, lex_begin, lex_len);
                put_tok(K_IDENT, sat(lex_begin, lex_len), 1);
            end
            S_STR: put_tok(K_ERR_UNTERM, lex_begin, lex_len);
            S_SLASH: put_tok(K_SLASH, lex_begin, 1);
            S_BANG: put_tok(K_BANG, lex_begin, 1);
            S_EQ: put_tok(K_EQ, lex_begin, 1);
            S_GT: put_tok(K_GT, lex_begin, 1);
            S_LT: put_tok(K_LT, lex_begin, 1);
            S_AMP: put_tok(K_AND, lex_begin, 1);
            S_PIPE: put_tok(K_OR, lex_begin, 1);
            default: ;
        endcase
        lex_mode = S_IDLE;
    endtask

    function automatic void lex_pair(logic [6:0] kind);
        lex_len = sat(lex_len, 1);
        put_tok(kind, lex_begin, lex_len);
        lex_mode = S_IDLE;
    endfunction

    task automatic lex_start(logic [7:0] c);
        lex_begin = lex_offset;
        lex_len = 1;
        lex_mode = S_IDLE;
        if (is_dig(c)) lex_mode = S_INT;
        else if (is_alp(c)) begin
            lex_mode = S_IDENT;
            lex_word = 64'(c);
            lex_long = 0;
        end else begin
            case (c)
                "\"": lex_mode = S_STR;
                "(": put_tok(K_LPAREN, lex_begin, 1);
                ")": put_tok(K_RPAREN, lex_begin, 1);
                "{": put_tok(K_LBRACE, lex_begin, 1);
                "}": put_tok(K_RBRACE, lex_begin, 1);
                ",": put_tok(K_COMMA, lex_begin, 1);
                ":": put_tok(K_COLON, lex_begin, 1);
                ";": put_tok(K_SEMI, lex_begin, 1);
                "-": put_tok(K_MINUS, lex_begin, 1);
                "+": put_tok(K_PLUS, lex_begin, 1);
                "*": put_tok(K_STAR, lex_begin, 1);
                "%": put_tok(K_MOD, lex_begin, 1);
                "^": put_tok(K_XOR, lex_begin, 1);
                "~": put_tok(K_TILDE, lex_begin, 1);
                "/": lex_mode = S_SLASH;
                "!": lex_mode = S_BANG;
                "=": lex_mode = S_EQ;
                ">": lex_mode = S_GT;
                "<": lex_mode = S_LT;
                "&": lex_mode = S_AMP;
                "|": lex_mode = S_PIPE;
                " ", 8'h0d, 8'h09: ;
                8'h0a: lex_line = sat(lex_line, 1);
                default: put_tok(K_ERR_UNKNOWN, lex_begin, 1);
            endcase
        end
    endtask

    // returns 1 when the byte was absorbed into the current token
    function automatic bit lex_continue(logic [7:0] c);
        case (lex_mode)
            S_IDENT: if (is_dig(c) || is_alp(c) || c == "_") begin
                ident_add(c); return 1;
            end
            S_INT: begin
                if (is_dig(c)) begin lex_len = sat(lex_len, 1); return 1; end
                if (c == ".") begin lex_pend = c; lex_mode = S_DOT; return 1; end
                if (c == "x" || c == "X") begin lex_pend = c; lex_mode = S_X; return 1; end
            end
            S_DOT: if (is_dig(c)) begin
                lex_len = sat(lex_len, 2); lex_mode = S_FRAC; return 1;
            end
            S_X: begin
                if (is_dig(c) || is_alp(c)) begin
                    lex_len = sat(lex_len, 2); lex_mode = S_HEX; return 1;
                end
                if (c == "_") begin
                    put_tok(K_NUMBER, lex_begin, lex_len);
                    lex_begin = sat(lex_begin, lex_len);
                    lex_len = 1;
                    lex_word = 64'(lex_pend);
                    lex_long = 0;
                    lex_mode = S_IDENT;
                    ident_add(c);
                    return 1;
                end
            end
            S_FRAC, S_HEX: if (is_dig(c) || (lex_mode == S_HEX && is_alp(c))) begin
                lex_len = sat(lex_len, 1); return 1;
            end
            S_STR: begin
                lex_len = sat(lex_len, 1);
                if (c == "\"") begin
                    put_tok(K_STRING, lex_begin, lex_len); lex_mode = S_IDLE;
                end else if (c == 8'h0a) lex_line = sat(lex_line, 1);
                return 1;
            end
            S_CMT: begin
                if (c != 8'h0a) return 1;
                lex_mode = S_IDLE;
            end
            S_SLASH: if (c == "/") begin lex_mode = S_CMT; return 1; end
            S_BANG: if (c == "=") begin lex_pair(K_BANG_EQ); return 1; end
            S_EQ: if (c == "=") begin lex_pair(K_EQ_EQ); return 1; end
            S_GT: begin
                if (c == ">") begin lex_pair(K_SHR); return 1; end
                if (c == "=") begin lex_pair(K_GE); return 1; end
            end
            S_LT: begin
                if (c == "<") begin lex_pair(K_SHL); return 1; end
                if (c == "=") begin lex_pair(K_LE); return 1; end
            end
            S_AMP: if (c == "&") begin lex_pair(K_AND_AND); return 1; end
            S_PIPE: if (c == "|") begin lex_pair(K_OR_OR); return 1; end
            default: ;
        endcase
        return 0;
    endfunction

    task automatic predict_tokens(t_in_beat b);
        run_toks.delete();
        if (b.end_of_text || b.char_code == 8'd0) begin
            lex_flush();
            put_tok(K_END, lex_offset, 0);
            lex_clear();
        end else begin
            if (!lex_continue(b.char_code)) begin
                lex_flush();
                lex_start(b.char_code);
            end
            lex_offset = sat(lex_offset, 1);
        end
        if (run_toks.size() > 0) run_toks[run_toks.size()-1].last_of_run = 1'b1;
        foreach (run_toks[i]) tokens_due.push_back(run_toks[i]);
    endtask

    // sender: bursts and gaps, drives at the falling edge
    task automatic send_beat(logic [7:0] c, bit eot = 1'b0);
        t_in_beat b;
        b.char_code = c;
        b.end_of_text = eot;
        @(negedge i_clk);
        if (burst_left == 0) begin
            i_valid <= 1'b0;
            do @(negedge i_clk); while ($urandom_range(0, 3) != 0);
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        i_data <= b;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (!o_ready);
        predict_tokens(b);
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) send_beat(s[i]);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (tokens_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // receiver: stall pattern plus a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_off) begin
            i_ready <= 1'b0;
            hold_cycles++;
            if (hold_cycles >= 60) hold_off = 1'b0;
        end else if (($urandom_range(0, 63) < 8) && ($time % 200 < 120)) i_ready <= 1'b0;
        else i_ready <= 1'b1;
    end

    // token checker
    always @(posedge i_clk) begin
        t_out_beat want;
        if (i_rst_n && o_valid && i_ready) begin
            if (tokens_due.size() == 0) begin
                $error("unexpected token kind %0d", o_data.token_kind);
                fail_count++;
            end else begin
                want = tokens_due.pop_front();
                if (o_data.token_kind !== want.token_kind) begin
                    $error("token_kind exp %0d got %0d", want.token_kind, o_data.token_kind);
                    fail_count++;
                end
                if (o_data.token_start !== want.token_start) begin
                    $error("token_start exp %0d got %0d", want.token_start,
                           o_data.token_start);
                    fail_count++;
                end
                if (o_data.token_length !== want.token_length) begin
                    $error("token_length exp %0d got %0d", want.token_length,
                           o_data.token_length);
                    fail_count++;
                end
                if (o_data.token_line !== want.token_line) begin
                    $error("token_line exp %0d got %0d", want.token_line,
                           o_data.token_line);
                    fail_count++;
                end
                if (o_data.last_of_run !== want.last_of_run) begin
                    $error("last_of_run exp %0d got %0d", want.last_of_run,
                           o_data.last_of_run);
                    fail_count++;
                end
            end
        end
    end

    // watchdog on accepted beats
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic test_operators();
        send_text("(){},:;-+*%^~/ ! != = == > >= >> < <= << & && | || x");
        send_beat(8'h00);
    endtask

    task automatic test_keywords();
        send_text("if elseif else let const return true false null fn for while print ");
        send_text("pointer string bool void int8 int16 int32 int64 uint8 uint16 uint32 ");
        send_text("uint64 float8 float16 float32 float64 ufloat8 ufloat16 ufloat32 ufloat64");
        send_text(" ufloat640 elseifx Zz_9");
        send_beat(8'h41, 1'b1);
    endtask

    task automatic test_numbers();
        send_text("12 3.5 7.a 0x1F 4x 5x_ 9X; 6. 8.");
        send_beat(8'h00, 1'b1);
    endtask

    task automatic test_strings_comments();
        send_text("\"ab\ncd\" // note ~~\n_ @");
        send_beat(8'hff);
        send_beat(8'h80);
        send_text("\"open\n");
        send_beat(8'h00);
    endtask

    function automatic logic [7:0] pick_char();
        string alpha = "abcdefgiloprstuvwxnXZ0123456789_.\"/!=<>&|(){},:;-+*%^~ \n\t\r";
        if ($urandom_range(0, 19) == 0) return 8'($urandom_range(1, 255));
        return alpha[$urandom_range(0, alpha.len() - 1)];
    endfunction

    task automatic test_random_text();
        string words[8] = '{"if", "elseif", "return", "pointer", "ufloat64", "fn",
                            "print", "int8"};
        int sent;
        bit held;
        bit drained;
        sent = 0;
        held = 1'b0;
        drained = 1'b0;
        while (sent < 30) begin
            if (!held && sent >= 5) begin
                held = 1'b1;
                hold_cycles = 0;
                hold_off = 1'b1;
            end
            if (!drained && sent >= 18) begin
                drained = 1'b1;
                wait_drained();
            end
            case ($urandom_range(0, 5))
                0: begin
                    send_text(words[$urandom_range(0, 7)]);
                    send_beat(" ");
                    sent += 4;
                end
                1: begin
                    send_text("0x7f 3.25 ");
                    sent += 10;
                end
                default: begin
                    send_beat(pick_char());
                    sent++;
                end
            endcase
            if ($urandom_range(0, 49) == 0) begin
                send_beat(8'($urandom_range(0, 255)), 1'b1);
                sent++;
            end
        end
        send_beat(8'h00, 1'b1);
    endtask

    initial begin
        lex_clear();
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_operators();
        test_keywords();
        test_numbers();
        test_strings_comments();
        test_random_text();
        wait_drained();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && tokens_due.size() == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end
endmodule
`default_nettype wire

// ===== script_source_tokenizer.f =====
hw/rtl/sst_pkg.sv
hw/rtl/sst_kw_match.sv
hw/rtl/sst_scan.sv
hw/rtl/sst_out_queue.sv
hw/rtl/script_source_tokenizer.sv
bench/tb_script_source_tokenizer.sv
